// File: src/jfd_pkg.sv
// ---------------------------------------------------------------------------
// jfd_pkg: shared types and constants of the jpeg frame delimiter
// marker byte values, field widths and the result beat record
// ---------------------------------------------------------------------------
package jfd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 21;

  // largest value that the length field can carry
  localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
  // smallest frame limit that the block honors
  localparam logic [LEN_W-1:0] LIMIT_MIN = LEN_W'(4);

  localparam logic [BYTE_W-1:0] MARK_LEAD = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_SOI  = 8'hD8;
  localparam logic [BYTE_W-1:0] MARK_EOI  = 8'hD9;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
    logic              last;
    logic              error;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

// File: src/jfd_parser.sv
// ---------------------------------------------------------------------------
// jfd_parser: marker tracking and frame byte counting
// consumes one byte per enabled cycle and yields zero, one or two beats
// ---------------------------------------------------------------------------
module jfd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [jfd_pkg::BYTE_W-1:0] in_byte,
  input  logic [jfd_pkg::LEN_W-1:0]  limit,
  output logic [1:0]                res_count,
  output jfd_pkg::result_t          res0,
  output jfd_pkg::result_t          res1
);

  localparam logic [1:0] PH_HUNT     = 2'd0;
  localparam logic [1:0] PH_AFTER_FF = 2'd1;
  localparam logic [1:0] PH_FRAME    = 2'd2;

  logic [1:0]                phase, phase_next;
  logic                      last_ff, last_ff_next;
  logic [jfd_pkg::LEN_W-1:0] byte_count, byte_count_next;
  logic [jfd_pkg::LEN_W-1:0] cnt;
  logic                      closes;

  assign cnt    = byte_count + jfd_pkg::LEN_W'(1);
  assign closes = last_ff && (in_byte == jfd_pkg::MARK_EOI);

  always_comb begin
    phase_next      = phase;
    last_ff_next    = last_ff;
    byte_count_next = byte_count;
    res_count       = 2'd0;
    res0            = '0;
    res1            = '0;
    unique case (phase)
      PH_AFTER_FF: begin
        if (in_byte == jfd_pkg::MARK_SOI) begin
          res_count       = 2'd2;
          res0.data       = jfd_pkg::MARK_LEAD;
          res0.start      = 1'b1;
          res0.length     = jfd_pkg::LEN_W'(1);
          res1.data       = jfd_pkg::MARK_SOI;
          res1.length     = jfd_pkg::LEN_W'(2);
          phase_next      = PH_FRAME;
          byte_count_next = jfd_pkg::LEN_W'(2);
          last_ff_next    = 1'b0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_FRAME: begin
        res_count   = 2'd1;
        res0.data   = in_byte;
        res0.length = cnt;
        if (closes || cnt >= limit) begin
          // eoi wins over the limit when both land on the same byte
          res0.last       = 1'b1;
          res0.error      = !closes;
          phase_next      = PH_HUNT;
          byte_count_next = '0;
          last_ff_next    = 1'b0;
        end else begin
          byte_count_next = cnt;
          last_ff_next    = (in_byte == jfd_pkg::MARK_LEAD);
        end
      end
      default: begin
        // hunting, unused code included
        phase_next      = (in_byte == jfd_pkg::MARK_LEAD) ? PH_AFTER_FF : PH_HUNT;
        byte_count_next = '0;
        last_ff_next    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      last_ff    <= 1'b0;
      byte_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      last_ff    <= last_ff_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

// File: src/jfd_out_fifo.sv
// ---------------------------------------------------------------------------
// jfd_out_fifo: four-entry result queue
// takes up to two beats per cycle; while out_ready is high it hands out one beat per cycle
// ---------------------------------------------------------------------------
module jfd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  jfd_pkg::result_t push0,
  input  jfd_pkg::result_t push1,
  output logic [2:0]       level,
  output logic             out_valid,
  input  logic             out_ready,
  output jfd_pkg::result_t out_beat
);

  jfd_pkg::result_t entry [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [1:0] wr_ptr_plus1;
  logic       pop;

  assign out_valid    = (level != 3'd0);
  assign out_beat     = entry[rd_ptr];
  assign pop          = out_valid && out_ready;
  assign wr_ptr_plus1 = wr_ptr + 2'd1;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entry[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entry[wr_ptr_plus1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      level  <= level + {1'b0, push_count} - {2'b00, pop};
    end
  end

endmodule

// File: src/jpeg_frame_delimiter_unit.sv
// ---------------------------------------------------------------------------
// jpeg_frame_delimiter_unit: cuts jpeg frames out of a raw byte stream
// hunts for soi, passes frame bytes with start, end and length marks
// ---------------------------------------------------------------------------
// The block takes one stream byte per beat and emits the bytes of each jpeg
// frame found between an ff d8 (soi) and an ff d9 (eoi) pair. Bytes outside a
// frame are dropped; a byte that follows ff while hunting is always consumed,
// so ff ff d8 opens no frame. The soi byte yields two output beats (ff with
// the start flag, then d8). Every frame beat carries the running length,
// which is the total on the tlast beat. A frame that reaches the configured
// limit without closing ends with tlast and the error flag set. Rate: one byte
// per clock cycle while the output accepts beats; the extra soi beat is
// absorbed because the ff before it produces nothing. Input beats pass the
// input register, then the result queue. The input register advances when the
// four-entry result queue holds at most two beats, so output stalls throttle
// the input only once it holds three beats or more. The user must write the
// limit register via the cfg port only while the block is idle (unenforced);
// on write it is clamped to [4, MAX_FRAME] and the 21-bit length range.
module jpeg_frame_delimiter_unit #(
  parameter int MAX_FRAME = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [28:8] frame_length, [31:29] zero
  output logic        m_axis_tlast,   // frame_end
  output logic [1:0]  m_axis_tuser,   // [0] frame_start, [1] frame_error
  // limit register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data        // max_frame_bytes
);

  // upper clamp of the limit: the parameter, bounded by the length field
  localparam logic [jfd_pkg::LEN_W-1:0] LIMIT_CAP =
    (MAX_FRAME > 2097151) ? jfd_pkg::LEN_MAX : jfd_pkg::LEN_W'(MAX_FRAME);
  localparam logic [jfd_pkg::LEN_W-1:0] LIMIT_RESET =
    (LIMIT_CAP > jfd_pkg::LEN_W'(1048576)) ? jfd_pkg::LEN_W'(1048576) : LIMIT_CAP;

  // effective limit, stored already clamped
  logic [jfd_pkg::LEN_W-1:0] limit, limit_next;

  // input register
  logic                       in_valid;
  logic [jfd_pkg::BYTE_W-1:0] in_byte;
  logic                       advance;

  // parser results and queue state
  logic [1:0]       res_count;
  logic [1:0]       push_count;
  jfd_pkg::result_t res0, res1;
  jfd_pkg::result_t out_beat;
  logic [2:0]       level;

  assign cfg_ready = 1'b1;

  always_comb begin
    limit_next = cfg_data;
    if (cfg_data < jfd_pkg::LIMIT_MIN) begin
      limit_next = jfd_pkg::LIMIT_MIN;
    end else if (cfg_data > LIMIT_CAP) begin
      limit_next = LIMIT_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= limit_next;
    end
  end

  // the held byte is processed once the queue has room for two beats
  assign advance       = in_valid && (level <= 3'd2);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  jfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_byte),
    .limit     (limit),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  assign push_count = advance ? res_count : 2'd0;

  jfd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .level      (level),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_beat   (out_beat)
  );

  // beat packing
  assign m_axis_tdata = {3'b000, out_beat.length, out_beat.data};
  assign m_axis_tlast = out_beat.last;
  assign m_axis_tuser = {out_beat.error, out_beat.start};

endmodule

// File: src/jfd_checker.sv
// ---------------------------------------------------------------------------
// jfd_port_checker: port-level checks of the frame delimiter
// watches the output stream for malformed frame beats
// ---------------------------------------------------------------------------
module jfd_port_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [1:0]  m_axis_tuser
);

  // a stalled beat holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // an error beat always closes its frame
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("error flag without tlast");

  // start beat is the ff of soi, length one, never the last
  a_start_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[7:0] == jfd_pkg::MARK_LEAD && m_axis_tdata[28:8] == 21'd1
      && !m_axis_tlast && !m_axis_tuser[1])
    else $error("malformed start beat");

  // the start beat is always followed by the d8 beat of length two
  a_soi_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=>
      m_axis_tvalid && m_axis_tdata[7:0] == jfd_pkg::MARK_SOI
      && m_axis_tdata[28:8] == 21'd2)
    else $error("soi beat pair broken");

  // every beat carries a nonzero length, and bits [31:29] are zero
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[28:8] != 21'd0 && m_axis_tdata[31:29] == 3'd0)
    else $error("bad length field");

endmodule

bind jpeg_frame_delimiter_unit jfd_port_checker u_jfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
